// ===== hw/rtl/quicksort_key_sorter_assert.svh =====
// assertion macros for the key sorter
// used by quicksort_key_sorter.sv, expects clk and rst_n in scope
`ifndef QUICKSORT_KEY_SORTER_ASSERT_SVH
`define QUICKSORT_KEY_SORTER_ASSERT_SVH
`ifndef SYNTHESIS
`define QKS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QKS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QKS_ASSERT(label, prop, msg)
`define QKS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== hw/rtl/qks_pkg.sv =====
// shared types and constants for the key sorter
// no dependencies
package qks_pkg;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic load;   // insert the broadcast key
    logic shift;  // move every key one cell toward the head
  } cell_ctrl_t;

  typedef struct packed {
    logic valid;  // cell holds a key
    logic gt;     // cell key above the broadcast key, or cell empty
  } cell_link_t;

endpackage

// ===== hw/rtl/quicksort_key_sorter.sv =====
// top level of the key sorter: chain of insertion cells plus load/drain control
// depends on qks_pkg, qks_cell and quicksort_key_sorter_assert.svh
//
// usage:
//   in_*  : keys, one item per key; in_tlast marks the final key of a set
//   out_* : the stored keys in ascending order, out_tlast on the largest,
//           out_tuser set on every item of a set that lost keys to a full store
// each accepted key that finds room is inserted in place in the same cycle by a broadcast
// compare across MAX_KEYS cells, so the chain is always sorted
// loading accepts keys back to back; after the final key the first result is
// valid on the next cycle and one result leaves per cycle the receiver takes
// each set is loaded and then drained, the drain going through the single
// head-of-chain read port
// in_tready is low while a set drains; a stalled receiver just holds the chain
// keys arriving with the store full are dropped, a dropped final key still
// closes the set
// reset (rst_n low, synchronous) empties the chain and returns to loading
`include "quicksort_key_sorter_assert.svh"
module quicksort_key_sorter #(
  parameter int MAX_KEYS = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [qks_pkg::DATA_W-1:0]  in_tdata,   // [31:0] key
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [qks_pkg::DATA_W-1:0]  out_tdata,  // [31:0] sorted_key
  output logic                        out_tlast,
  output logic                        out_tuser   // [0] overflow
);
  import qks_pkg::*;

  localparam int KW = (KEY_BITS < DATA_W) ? KEY_BITS : DATA_W;

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic          state_r, state_nxt;
  logic          dropped_r, dropped_nxt;
  logic          in_acc, out_acc, full;
  logic [KW-1:0] ins_key;
  cell_ctrl_t    ctrl;

  logic [KW-1:0]   key_vec [MAX_KEYS];
  cell_link_t      link_vec [MAX_KEYS];
  logic [MAX_KEYS-1:0] valid_vec;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign full      = valid_vec[MAX_KEYS-1];
  assign ins_key   = in_tdata[KW-1:0];

  assign ctrl.load  = in_acc && !full;
  assign ctrl.shift = out_acc;

  genvar i;
  generate
    for (i = 0; i < MAX_KEYS; i++) begin : g_cell
      logic [KW-1:0] prev_key, next_key;
      cell_link_t    prev_link;
      logic          next_valid;

      assign valid_vec[i] = link_vec[i].valid;

      if (i == 0) begin : g_head
        assign prev_key        = '0;
        assign prev_link.valid = 1'b1;
        assign prev_link.gt    = 1'b0;
      end else begin : g_body
        assign prev_key  = key_vec[i-1];
        assign prev_link = link_vec[i-1];
      end

      if (i == MAX_KEYS - 1) begin : g_tail
        assign next_key   = key_vec[i];
        assign next_valid = 1'b0;
      end else begin : g_mid
        assign next_key   = key_vec[i+1];
        assign next_valid = link_vec[i+1].valid;
      end

      qks_cell #(.KW(KW)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .ins_key    (ins_key),
        .prev_key   (prev_key),
        .prev_link  (prev_link),
        .next_key   (next_key),
        .next_valid (next_valid),
        .key_q      (key_vec[i]),
        .link       (link_vec[i])
      );
    end
  endgenerate

  assign out_tvalid = (state_r == ST_DRAIN);
  assign out_tdata  = DATA_W'(key_vec[0]);
  assign out_tlast  = !valid_vec[1];
  assign out_tuser  = dropped_r;

  always_comb begin
    state_nxt   = state_r;
    dropped_nxt = dropped_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && full) begin
          dropped_nxt = 1'b1;
        end
        if (in_acc && in_tlast) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc && out_tlast) begin
          state_nxt   = ST_LOAD;
          dropped_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // occupied cells always form a prefix of the chain
  `QKS_ASSERT(a_valid_prefix, ((valid_vec >> 1) & ~valid_vec) == '0, "gap in sorter chain")
  // head cell holds a key for the whole drain
  `QKS_ASSERT(a_drain_head, state_r == ST_DRAIN |-> valid_vec[0], "drain with empty head")
  // last result leaves the chain empty and loading again
  `QKS_ASSERT(a_drain_end, out_acc && out_tlast |=> state_r == ST_LOAD && !valid_vec[0],
    "chain not empty after last result")
  // overflow is only raised by a key arriving at a full chain
  `QKS_ASSERT(a_drop_full, $rose(dropped_r) |-> $past(in_acc && full), "spurious overflow")
  `QKS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> valid_vec == '0 && state_r == ST_LOAD,
    "reset did not empty chain")

endmodule

// ===== hw/rtl/qks_cell.sv =====
// one cell of the sorting chain: holds a key, inserts or shifts toward the head
// depends on qks_pkg
module qks_cell #(
  parameter int KW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qks_pkg::cell_ctrl_t  ctrl,
  input  logic [KW-1:0]        ins_key,
  input  logic [KW-1:0]        prev_key,
  input  qks_pkg::cell_link_t  prev_link,
  input  logic [KW-1:0]        next_key,
  input  logic                 next_valid,
  output logic [KW-1:0]        key_q,
  output qks_pkg::cell_link_t  link
);
  import qks_pkg::*;

  logic [KW-1:0] key_r, key_nxt;
  logic          valid_r, valid_nxt;
  logic          gt;

  assign gt         = !valid_r || (key_r > ins_key);
  assign link.valid = valid_r;
  assign link.gt    = gt;
  assign key_q      = key_r;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      key_nxt   = next_key;
      valid_nxt = next_valid;
    end else if (ctrl.load && gt) begin
      // first cell above the new key takes it, the rest take their left neighbor
      key_nxt   = prev_link.gt ? prev_key : ins_key;
      valid_nxt = valid_r | prev_link.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for quicksort_key_sorter: key sets stream in, sorted keys stream out
// expected items come from a sorting model of each set; depends on qks_pkg and the sorter rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_KEYS = 64;
  localparam int KW = qks_pkg::DATA_W;
  localparam int LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT = 20;
  localparam int PHASE_KEYS = 30;
  localparam int SEND_IDLE [4] = '{0, 54, 0, 15};
  localparam int RECV_STALL [4] = '{0, 0, 54, 15};

  typedef struct {
    logic [KW-1:0] key;
    logic          last;
    int            send_idle;
    int            recv_stall;
    bit            pause;
    bit            hold;
  } key_item_t;

  typedef struct {
    logic [KW-1:0] key;
    logic          last;
    logic          ovf;
  } sorted_item_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [KW-1:0] in_tdata = '0;
  logic          in_tlast = 1'b0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [KW-1:0] out_tdata;
  logic          out_tlast;
  logic          out_tuser;

  quicksort_key_sorter #(
    .MAX_KEYS(MAX_KEYS),
    .KEY_BITS(KW)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_item_t     pending_keys[$];
  key_item_t     bus_key;
  sorted_item_t  sorted_keys[$];
  sorted_item_t  want;
  logic [KW-1:0] key_set [MAX_KEYS];
  int            set_count = 0;
  bit            set_dropped = 1'b0;
  bit            in_took = 1'b0;
  int            keys_taken = 0;
  int            key_total = 0;
  int            errors = 0;
  int            recv_stall_pct = 0;
  int            hold_req = 0;
  int            hold_seen = 0;
  int            hold_left = 0;
  int            cycles = 0;

  // stimulus build state
  int            phase_send = 0;
  int            phase_recv = 0;
  bit            next_pause = 1'b0;
  bit            next_hold = 1'b0;

  // store a key of the current set; on the final key sort the set and queue its items
  task automatic collect_key(input logic [KW-1:0] key, input logic last);
    logic [KW-1:0] v;
    int            j;
    sorted_item_t  r;
    if (set_count < MAX_KEYS) begin
      key_set[set_count] = key;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      for (int i = 1; i < set_count; i++) begin
        v = key_set[i];
        j = i;
        while (j > 0 && key_set[j-1] > v) begin
          key_set[j] = key_set[j-1];
          j--;
        end
        key_set[j] = v;
      end
      for (int i = 0; i < set_count; i++) begin
        r.key = key_set[i];
        r.last = (i == set_count - 1);
        r.ovf = set_dropped;
        sorted_keys = {sorted_keys, r};
      end
      set_count = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic add_key(input logic [KW-1:0] key, input logic last);
    key_item_t it;
    it.key = key;
    it.last = last;
    it.send_idle = phase_send;
    it.recv_stall = phase_recv;
    it.pause = next_pause;
    it.hold = last && next_hold;
    next_pause = 1'b0;
    if (last) next_hold = 1'b0;
    pending_keys = {pending_keys, it};
  endtask

  task automatic add_random_set(input int n);
    logic [KW-1:0] k;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: k = $urandom_range(7);  // small pool for duplicates
        3: begin
          case ($urandom_range(3))
            0: k = '0;
            1: k = '1;
            2: k = {1'b1, {(KW-1){1'b0}}};
            default: k = {1'b0, {(KW-1){1'b1}}};
          endcase
        end
        default: k = $urandom;
      endcase
      add_key(k, i == n - 1);
    end
  endtask

  // driver: offer the next pending item once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      if (pending_keys.size() != 0 &&
          !(pending_keys[0].pause && sorted_keys.size() != 0) &&
          $urandom_range(99) >= pending_keys[0].send_idle) begin
        bus_key = pending_keys.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= bus_key.key;
        in_tlast <= bus_key.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // monitor: check results first, then take in accepted keys
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_keys.size() == 0) begin
        $display("%0t: unexpected item key=%h last=%b ovf=%b", $time,
                 out_tdata, out_tlast, out_tuser);
        errors++;
      end else begin
        want = sorted_keys.pop_front();
        if (out_tdata !== want.key || out_tlast !== want.last || out_tuser !== want.ovf) begin
          $display("%0t: mismatch expected key=%h last=%b ovf=%b got key=%h last=%b ovf=%b",
                   $time, want.key, want.last, want.ovf, out_tdata, out_tlast, out_tuser);
          errors++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      in_took <= 1'b1;
      keys_taken <= keys_taken + 1;
      recv_stall_pct <= bus_key.recv_stall;
      if (bus_key.hold) hold_req <= hold_req + 1;
      collect_key(in_tdata, in_tlast);
    end else begin
      in_took <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    int budget;
    // directed sets: single keys, pairs, all equal, reversed, ascending, extremes
    add_key('0, 1'b1);
    add_key('1, 1'b1);
    add_key('1, 1'b0);
    add_key('0, 1'b1);
    add_key(32'd5, 1'b0);
    add_key(32'd5, 1'b1);
    for (int i = 0; i < 4; i++) add_key(32'd7, i == 3);
    for (int i = 0; i < 5; i++) add_key(32'd50 - 32'd10 * i, i == 4);
    for (int i = 1; i <= 3; i++) add_key(i, i == 3);
    add_key(32'h8000_0000, 1'b0);
    add_key(32'h7fff_ffff, 1'b0);
    add_key('0, 1'b0);
    add_key('1, 1'b1);

    for (int p = 0; p < 4; p++) begin
      phase_send = SEND_IDLE[p];
      phase_recv = RECV_STALL[p];
      next_pause = 1'b1;
      // long receiver hold-off after the first set while the next one is offered
      if (p == 0) next_hold = 1'b1;
      budget = PHASE_KEYS;
      while (budget > 0) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
        if (n > budget) n = budget;
        add_random_set(n);
        budget -= n;
      end
      // store full: one key past capacity, the dropped one being the final key
      if (p == 2) add_random_set(MAX_KEYS + 1);
    end
    key_total = pending_keys.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (keys_taken != key_total) @(negedge clk);
    while (sorted_keys.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0 && sorted_keys.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
